/* hw/rtl/ige_pkg.sv */
package ige_pkg;

    localparam int BAND_COUNT = 10;
    localparam int HIST_W     = 40;
    localparam int SLOT_W     = 3 * HIST_W;
    localparam int DIGITS     = 8;

    typedef logic signed [31:0] coef_t;

    // Q2.30 band-pass coefficients per band.
    localparam coef_t ALPHA [BAND_COUNT] = '{
        32'sd1070769041, 32'sd1067365324, 32'sd1060580731, 32'sd1047135710,
        32'sd1021188910, 32'sd971208548,  32'sd878095022,  32'sd717873561,
        32'sd481694903,  32'sd259858856
    };
    localparam coef_t BETA [BAND_COUNT] = '{
        32'sd1486392,   32'sd3188250,   32'sd6580546,   32'sd13303057,
        32'sd26276457,  32'sd51266638,  32'sd97823401,  32'sd177934132,
        32'sd296023461, 32'sd406941484
    };
    localparam coef_t GAMMA [BAND_COUNT] = '{
        32'sd2144489609, 32'sd2141022260, 32'sd2133984085, 32'sd2119532287,
        32'sd2089617260, 32'sd2024229856, 32'sd1873129701, 32'sd1508456098,
        32'sd649814787,  -32'sd868089318
    };

    localparam logic [2:0] REG_GAINS_0_3 = 3'd0;
    localparam logic [2:0] REG_GAINS_4_7 = 3'd1;
    localparam logic [2:0] REG_GAINS_8_9 = 3'd2;
    localparam logic [2:0] REG_PREAMP    = 3'd3;
    localparam logic [2:0] REG_EXTRA     = 3'd4;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_START = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_SEC   = 9'b000010000,
        S_GMUL  = 9'b000100000,
        S_ACC   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    localparam logic signed [49:0] SAT_HI = 50'sd549755813887;
    localparam logic signed [49:0] SAT_LO = -50'sd549755813888;

    function automatic logic signed [HIST_W-1:0] sat40(input logic signed [49:0] v);
        logic signed [HIST_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[HIST_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[HIST_W-1:0];
        else
            r = v[HIST_W-1:0];
        return r;
    endfunction

endpackage

/* hw/rtl/ige_ram.sv */
module ige_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ige_serial_mul.sv */
module ige_serial_mul
    import ige_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                shift24,
    input  logic signed [40:0]  a,
    input  logic signed [31:0]  c,
    output logic                busy,
    output logic signed [47:0]  res
);

    logic signed [40:0] a_reg;
    logic [31:0]        c_reg;
    logic signed [46:0] hi_reg;
    logic [31:0]        lo_reg;
    logic [2:0]         cnt_reg;
    logic               busy_reg;
    logic               s24_reg;

    logic signed [4:0]  dig;
    logic signed [45:0] pp;
    logic signed [46:0] sum;
    logic signed [48:0] r30;
    logic signed [54:0] r24;

    // The top digit of the multiplier carries negative weight.
    assign dig = (cnt_reg == 3'(DIGITS - 1)) ? $signed({c_reg[3], c_reg[3:0]})
                                              : $signed({1'b0, c_reg[3:0]});
    assign pp  = a_reg * dig;
    assign sum = hi_reg + 47'(pp);

    // Round half up: floor of the shifted product plus the first dropped bit.
    assign r30 = $signed({hi_reg, lo_reg[31:30]}) + $signed({48'h0, lo_reg[29]});
    assign r24 = $signed({hi_reg, lo_reg[31:24]}) + $signed({54'h0, lo_reg[23]});

    assign res  = s24_reg ? r24[47:0] : r30[47:0];
    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'(DIGITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            c_reg   <= c;
            hi_reg  <= '0;
            lo_reg  <= '0;
            s24_reg <= shift24;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum >>> 4;
            lo_reg <= {sum[3:0], lo_reg[31:4]};
            c_reg  <= c_reg >> 4;
        end
    end

endmodule

/* hw/rtl/iir_graphic_equalizer_top.sv */
// Stereo ten-band IIR graphic equalizer. One frame is taken at a time and its
// result is held in an output register, so the next frame may be taken while
// that result waits. In each band section its three coefficient products run
// in parallel on three 4-bit digit-serial multipliers, then the gain product
// reuses the first one. A second filter pass over the bands can be enabled.
// History memories come out of reset reading zero through per-entry valid
// flags, so no clearing pass is needed.
module iir_graphic_equalizer_top
    import ige_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic               block_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               block_end_out,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    state_t state_reg, state_next;

    logic [63:0]        gain0_reg, gain1_reg;
    logic [31:0]        gain2_reg;
    logic signed [15:0] pre_reg;
    logic               extra_reg;

    logic signed [15:0] smpl_reg, smpr_reg;
    logic               be_reg;
    logic signed [15:0] xl1_reg, xl2_reg, xr1_reg, xr2_reg;
    logic [1:0]         phase_reg;
    logic               ch_reg, pass_reg;
    logic [3:0]         band_reg;
    logic signed [39:0] acc_reg;
    logic signed [15:0] lres_reg, rres_reg;
    logic               out_valid_reg;
    logic signed [15:0] lout_reg, rout_reg;
    logic               beout_reg;
    logic [63:0]        yval_reg;
    logic [31:0]        xval_reg;
    logic               yok_reg, xok_reg;

    logic [1:0]         pi, pj, pk;
    logic signed [15:0] smp, xk16, gsel;
    logic [SLOT_W-1:0]  yrd, xrd, yword, xword, ywdata, xwdata;
    logic signed [39:0] y1, y2, x2nd, y_new, acc_sum;
    logic signed [40:0] diff;
    logic signed [31:0] gp;
    logic signed [49:0] sec_sum;
    logic [5:0]         yaddr;
    logic [4:0]         xaddr;
    logic               y_we, x_we, out_free;
    logic signed [40:0] m0_a;
    logic signed [31:0] m0_c;
    logic               m0_start, m12_start, m0_s24;
    logic               m0_busy, m1_busy, m2_busy;
    logic signed [47:0] m0_res, m1_res, m2_res;
    logic signed [15:0] sq;
    logic signed [41:0] v, vm;
    logic [25:0]        q;
    logic signed [26:0] rq;
    logic signed [15:0] rsat;

    function automatic logic signed [39:0] get_slot(input logic [SLOT_W-1:0] w,
                                                    input logic [1:0] idx);
        logic signed [39:0] r;
        unique case (idx)
            2'd1:    r = w[79:40];
            2'd2:    r = w[119:80];
            default: r = w[39:0];
        endcase
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] set_slot(input logic [SLOT_W-1:0] w,
                                                   input logic [1:0] idx,
                                                   input logic [39:0] d);
        logic [SLOT_W-1:0] r;
        r = w;
        unique case (idx)
            2'd1:    r[79:40]  = d;
            2'd2:    r[119:80] = d;
            default: r[39:0]   = d;
        endcase
        return r;
    endfunction

    // Slot pi takes the current value, pj holds n-1 and pk holds n-2.
    always_comb
    begin
        unique case (phase_reg)
            2'd1:
            begin
                pi = 2'd1; pj = 2'd0; pk = 2'd2;
            end
            2'd2:
            begin
                pi = 2'd2; pj = 2'd1; pk = 2'd0;
            end
            default:
            begin
                pi = 2'd0; pj = 2'd2; pk = 2'd1;
            end
        endcase
    end

    always_comb
    begin
        unique case (band_reg)
            4'd0:    gsel = gain0_reg[15:0];
            4'd1:    gsel = gain0_reg[31:16];
            4'd2:    gsel = gain0_reg[47:32];
            4'd3:    gsel = gain0_reg[63:48];
            4'd4:    gsel = gain1_reg[15:0];
            4'd5:    gsel = gain1_reg[31:16];
            4'd6:    gsel = gain1_reg[47:32];
            4'd7:    gsel = gain1_reg[63:48];
            4'd8:    gsel = gain2_reg[15:0];
            4'd9:    gsel = gain2_reg[31:16];
            default: gsel = '0;
        endcase
    end

    assign gp    = gsel * pre_reg;
    assign smp   = ch_reg ? smpr_reg : smpl_reg;
    assign xk16  = ch_reg ? xr2_reg : xl2_reg;
    assign yword = yok_reg ? yrd : '0;
    assign xword = xok_reg ? xrd : '0;
    assign y1    = get_slot(yword, pj);
    assign y2    = get_slot(yword, pk);
    assign x2nd  = get_slot(xword, pk);

    assign diff = pass_reg ? (41'(acc_reg) - 41'(x2nd))
                           : (41'($signed({smp, 16'h0})) - 41'($signed({xk16, 16'h0})));

    assign sec_sum = 50'(m0_res) + 50'(m1_res) - 50'(m2_res);
    assign y_new   = sat40(sec_sum);
    assign acc_sum = sat40(50'(acc_reg) + 50'(m0_res));

    assign yaddr  = {pass_reg, ch_reg, band_reg};
    assign xaddr  = {ch_reg, band_reg};
    assign y_we   = (state_reg == S_SEC);
    assign x_we   = (state_reg == S_SEC) && pass_reg;
    assign ywdata = set_slot(yword, pi, y_new);
    assign xwdata = set_slot(xword, pi, acc_reg);

    assign m0_start  = (state_reg == S_START) || (state_reg == S_SEC);
    assign m12_start = (state_reg == S_START);
    assign m0_s24    = (state_reg == S_SEC);
    assign m0_a      = (state_reg == S_SEC) ? 41'(y_new) : diff;
    assign m0_c      = (state_reg == S_SEC) ? gp : ALPHA[band_reg];

    // Output rounding: half away from zero, then clamp to 16 bits.
    assign sq = smp >>> 2;
    assign v  = 42'(acc_reg) + 42'($signed({sq[13:0], 16'h0}));
    assign vm = v[41] ? -v : v;
    assign q  = 26'((vm + 42'sd32768) >>> 16);
    assign rq = v[41] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign rsat = (rq > 27'sd32767) ? 16'sh7FFF :
                  (rq < -27'sd32768) ? -16'sh8000 : rq[15:0];

    assign out_free = !out_valid_reg || !out_stall;

    ige_ram #(.WIDTH(SLOT_W), .DEPTH(64)) u_yram (
        .clk   (clk),
        .we    (y_we),
        .waddr (yaddr),
        .wdata (ywdata),
        .raddr (yaddr),
        .rdata (yrd)
    );

    ige_ram #(.WIDTH(SLOT_W), .DEPTH(32)) u_xram (
        .clk   (clk),
        .we    (x_we),
        .waddr (xaddr),
        .wdata (xwdata),
        .raddr (xaddr),
        .rdata (xrd)
    );

    ige_serial_mul u_mul0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (m0_start),
        .shift24 (m0_s24),
        .a       (m0_a),
        .c       (m0_c),
        .busy    (m0_busy),
        .res     (m0_res)
    );

    ige_serial_mul u_mul1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (m12_start),
        .shift24 (1'b0),
        .a       (41'(y1)),
        .c       (GAMMA[band_reg]),
        .busy    (m1_busy),
        .res     (m1_res)
    );

    ige_serial_mul u_mul2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (m12_start),
        .shift24 (1'b0),
        .a       (41'(y2)),
        .c       (BETA[band_reg]),
        .busy    (m2_busy),
        .res     (m2_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_READ;
            S_READ:  state_next = S_START;
            S_START: state_next = S_MUL;
            S_MUL:   if (!m0_busy && !m1_busy && !m2_busy) state_next = S_SEC;
            S_SEC:   state_next = S_GMUL;
            S_GMUL:  if (!m0_busy) state_next = S_ACC;
            S_ACC:
            begin
                if (band_reg != 4'(BAND_COUNT - 1) || (!pass_reg && extra_reg))
                    state_next = S_READ;
                else
                    state_next = S_FIN;
            end
            S_FIN:   state_next = ch_reg ? S_OUT : S_READ;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain0_reg     <= 64'h0800_0800_0800_0800;
            gain1_reg     <= 64'h0800_0800_0800_0800;
            gain2_reg     <= 32'h0800_0800;
            pre_reg       <= 16'sd4096;
            extra_reg     <= 1'b0;
            xl1_reg       <= '0;
            xl2_reg       <= '0;
            xr1_reg       <= '0;
            xr2_reg       <= '0;
            phase_reg     <= '0;
            ch_reg        <= 1'b0;
            pass_reg      <= 1'b0;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
            yval_reg      <= '0;
            xval_reg      <= '0;
            yok_reg       <= 1'b0;
            xok_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            yok_reg   <= yval_reg[yaddr];
            xok_reg   <= xval_reg[xaddr];

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_GAINS_0_3: gain0_reg <= cfg_data;
                    REG_GAINS_4_7: gain1_reg <= cfg_data;
                    REG_GAINS_8_9: gain2_reg <= cfg_data[31:0];
                    REG_PREAMP:    pre_reg   <= cfg_data[15:0];
                    REG_EXTRA:     extra_reg <= cfg_data[0];
                    default:       ;
                endcase
            end

            if (y_we)
                yval_reg[yaddr] <= 1'b1;
            if (x_we)
                xval_reg[xaddr] <= 1'b1;

            if (state_reg == S_IDLE && in_valid)
            begin
                ch_reg   <= 1'b0;
                pass_reg <= 1'b0;
                band_reg <= '0;
            end

            if (state_reg == S_ACC)
            begin
                if (band_reg != 4'(BAND_COUNT - 1))
                begin
                    band_reg <= band_reg + 4'd1;
                end
                else if (!pass_reg && extra_reg)
                begin
                    pass_reg <= 1'b1;
                    band_reg <= '0;
                end
            end

            if (state_reg == S_FIN && !ch_reg)
            begin
                ch_reg   <= 1'b1;
                pass_reg <= 1'b0;
                band_reg <= '0;
            end

            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                xl2_reg       <= xl1_reg;
                xl1_reg       <= smpl_reg;
                xr2_reg       <= xr1_reg;
                xr1_reg       <= smpr_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            smpl_reg <= left_sample;
            smpr_reg <= right_sample;
            be_reg   <= block_end;
            acc_reg  <= '0;
        end
        if (state_reg == S_ACC)
            acc_reg <= acc_sum;
        if (state_reg == S_FIN)
        begin
            acc_reg <= '0;
            if (ch_reg)
                rres_reg <= rsat;
            else
                lres_reg <= rsat;
        end
        if (state_reg == S_OUT && out_free)
        begin
            lout_reg  <= lres_reg;
            rout_reg  <= rres_reg;
            beout_reg <= be_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_out      = lout_reg;
    assign right_out     = rout_reg;
    assign block_end_out = beout_reg;

endmodule
